FILE: hdl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared constants, codes and types of the ordered key-value table.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int CMD_W       = 3;
    localparam int KEY_FIELD_W = 32;
    localparam int VAL_FIELD_W = 32;
    localparam int POS_W       = 4;
    localparam int STATUS_W    = 3;
    localparam int HIT_W       = 4;
    localparam int COUNT_W     = 5;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic write_key;
        logic write_value;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/kvt_cell.sv
// ----------------------------------------------------------------------------
// kvt_cell
// One table entry: holds a key and a value, registers a key match and passes
// the first-match chain and its contents on to its neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_cell #(
    parameter int KEY_W   = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_W = kvt_pkg::VALUE_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire kvt_pkg::cell_ctrl_t ctrl,
    input  wire logic               occupied,
    input  wire logic [KEY_W-1:0]   cmp_key,
    input  wire logic [KEY_W-1:0]   wr_key,
    input  wire logic [VALUE_W-1:0] wr_value,
    input  wire logic [KEY_W-1:0]   nb_key,
    input  wire logic [VALUE_W-1:0] nb_value,
    input  wire logic               seen_in,
    output logic [KEY_W-1:0]        key_q,
    output logic [VALUE_W-1:0]      value_q,
    output logic                    seen_out,
    output logic                    first
);
    import kvt_pkg::*;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               match_reg, match_next;

    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        match_next = match_reg;
        if (ctrl.capture) begin
            match_next = occupied && (cmp_key == key_reg);
        end
        if (ctrl.shift) begin
            key_next   = nb_key;
            value_next = nb_value;
        end else begin
            if (ctrl.write_key) begin
                key_next = wr_key;
            end
            if (ctrl.write_value) begin
                value_next = wr_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign key_q    = key_reg;
    assign value_q  = value_reg;
    assign seen_out = seen_in | match_reg;
    assign first    = match_reg & ~seen_in;

endmodule

`default_nettype wire

FILE: hdl/ordered_key_value_table_core.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_core
// Insertion-ordered key-value table built as a row of entry cells.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: s_tuser carries the command (lookup, insert, remove, read,
//   write), s_tdata carries key, value and position
//   m_ channel: one result word per command; m_tuser carries the status,
//   m_tdata the hit position, the entry read and the entry count
//   every cell compares its key with the incoming key in the accept cycle
//   and registers the match; in the update state a first-match chain runs
//   along the row, the result is formed and the cells update (append,
//   value write, or shift down by one on removal)
//   the result word is registered in the output register when the cells update
//   one command at a time: no new command is taken until the previous one has
//   updated the cells; a new command is taken while a result waits
//   stall: if the output register is still full the update cycle waits, and
//   no further command is taken until that result has gone
//   reset (aresetn low, synchronous): table empty, output register empty;
//   entry contents are not cleared, only positions below the count are used
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_key_value_table_core #(
    parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // key [31:0], value [63:32], position [67:64]
    input  wire logic [kvt_pkg::S_TDATA_W-1:0]    s_tdata,
    // command
    input  wire logic [kvt_pkg::CMD_W-1:0]        s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // hit_position [3:0], out_key [35:4], out_value [67:36], entry_count [72:68]
    output logic [kvt_pkg::M_TDATA_W-1:0]         m_tdata,
    // status
    output logic [kvt_pkg::STATUS_W-1:0]          m_tuser
);
    import kvt_pkg::*;

    localparam int KEY_W   = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int VALUE_W = (VALUE_BITS < VAL_FIELD_W) ? VALUE_BITS : VAL_FIELD_W;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    logic s_accept, out_free, exec;

    logic [KEY_W-1:0]   in_key;
    logic [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]   in_pos;

    logic [KEY_W-1:0]     cell_key   [TABLE_DEPTH];
    logic [VALUE_W-1:0]   cell_value [TABLE_DEPTH];
    cell_ctrl_t           cell_ctrl  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] occ, seen_in_v, seen_out_v, first_v, sel_pos, sel_cnt;

    logic [IDX_W-1:0]   first_idx;
    logic [VALUE_W-1:0] first_value;
    logic [KEY_W-1:0]   pos_key;
    logic [VALUE_W-1:0] pos_value;

    logic                found, full, pos_ok;
    logic                ins_en, rm_en, wr_en;
    logic [STATUS_W-1:0] status;
    logic [31:0]         hit32, okey32, oval32, cnt32;
    logic [CNT_W-1:0]    count_after;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_value = s_tdata[32 +: VALUE_W];
    assign in_pos   = s_tdata[64 +: POS_W];

    // fsm: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // fsm: outputs
    always_comb begin
        s_tready = 1'b0;
        exec     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_EXEC: begin
                exec = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        if (s_accept) begin
            cmd_next   = s_tuser;
            key_next   = in_key;
            value_next = in_value;
            pos_next   = in_pos;
        end
    end

    // row of entry cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign occ[g]     = count_reg > CNT_W'(g);
        assign sel_cnt[g] = count_reg == CNT_W'(g);
        assign sel_pos[g] = 32'(pos_reg) == g;

        if (g == 0) begin : g_head
            assign seen_in_v[g] = 1'b0;
        end else begin : g_body
            assign seen_in_v[g] = seen_out_v[g-1];
        end

        assign cell_ctrl[g] = '{
            capture:     s_accept,
            write_key:   exec && ins_en && sel_cnt[g],
            write_value: exec && ((ins_en && sel_cnt[g]) || (wr_en && sel_pos[g])),
            shift:       exec && rm_en && seen_out_v[g]
        };

        if (g == TABLE_DEPTH - 1) begin : g_tail
            kvt_cell #(
                .KEY_W   (KEY_W),
                .VALUE_W (VALUE_W)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (cell_ctrl[g]),
                .occupied (occ[g]),
                .cmp_key  (in_key),
                .wr_key   (key_reg),
                .wr_value (value_reg),
                .nb_key   (cell_key[g]),
                .nb_value (cell_value[g]),
                .seen_in  (seen_in_v[g]),
                .key_q    (cell_key[g]),
                .value_q  (cell_value[g]),
                .seen_out (seen_out_v[g]),
                .first    (first_v[g])
            );
        end else begin : g_mid
            kvt_cell #(
                .KEY_W   (KEY_W),
                .VALUE_W (VALUE_W)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (cell_ctrl[g]),
                .occupied (occ[g]),
                .cmp_key  (in_key),
                .wr_key   (key_reg),
                .wr_value (value_reg),
                .nb_key   (cell_key[g+1]),
                .nb_value (cell_value[g+1]),
                .seen_in  (seen_in_v[g]),
                .key_q    (cell_key[g]),
                .value_q  (cell_value[g]),
                .seen_out (seen_out_v[g]),
                .first    (first_v[g])
            );
        end
    end

    // one-hot selection of the first match and of the addressed entry
    always_comb begin
        first_idx   = '0;
        first_value = '0;
        pos_key     = '0;
        pos_value   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (first_v[i]) begin
                first_idx   = first_idx | IDX_W'(i);
                first_value = first_value | cell_value[i];
            end
            if (sel_pos[i]) begin
                pos_key   = pos_key | cell_key[i];
                pos_value = pos_value | cell_value[i];
            end
        end
    end

    assign found  = seen_out_v[TABLE_DEPTH-1];
    assign full   = count_reg >= CNT_W'(TABLE_DEPTH);
    assign pos_ok = {{CNT_W{1'b0}}, pos_reg} < {{POS_W{1'b0}}, count_reg};

    always_comb begin
        status = ST_OK;
        hit32  = '0;
        okey32 = '0;
        oval32 = '0;
        ins_en = 1'b0;
        rm_en  = 1'b0;
        wr_en  = 1'b0;
        case (cmd_reg)
            CMD_LOOKUP: begin
                if (found) begin
                    hit32 = 32'(first_idx);
                end else begin
                    status = ST_ABSENT;
                end
            end
            CMD_INSERT: begin
                if (found) begin
                    status = ST_PRESENT;
                    hit32  = 32'(first_idx);
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    ins_en = 1'b1;
                    hit32  = 32'(count_reg);
                end
            end
            CMD_REMOVE: begin
                if (!found) begin
                    status = ST_ABSENT;
                end else if (first_value != value_reg) begin
                    status = ST_MISMATCH;
                    hit32  = 32'(first_idx);
                end else begin
                    rm_en = 1'b1;
                    hit32 = 32'(first_idx);
                end
            end
            CMD_READ: begin
                hit32 = 32'(pos_reg);
                if (pos_ok) begin
                    okey32 = 32'(pos_key);
                    oval32 = 32'(pos_value);
                end else begin
                    status = ST_BADPOS;
                end
            end
            CMD_WRITE: begin
                hit32 = 32'(pos_reg);
                if (pos_ok) begin
                    wr_en = 1'b1;
                end else begin
                    status = ST_BADPOS;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_comb begin
        count_after = count_reg;
        if (ins_en) begin
            count_after = count_reg + CNT_W'(1);
        end else if (rm_en) begin
            count_after = count_reg - CNT_W'(1);
        end
    end

    assign count_next = exec ? count_after : count_reg;
    assign cnt32      = 32'(count_after);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (exec) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'b0, cnt32[COUNT_W-1:0], oval32, okey32, hit32[HIT_W-1:0]};
            m_tuser_next  = status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_only_on_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg))) |-> $past(exec))
        else $error("entry count changed outside an update cycle");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ((count_reg == $past(count_reg))
                         || (count_reg == $past(count_reg) + CNT_W'(1))
                         || (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("entry count moved by more than one");

    a_first_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> $onehot0(first_v))
        else $error("more than one first match in the cell row");

endmodule

`default_nettype wire

FILE: tb/ordered_key_value_table_core_tb.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_core_tb
// Self-checking bench for the insertion-ordered key-value table. A short table
// of directed commands covers the empty and full table, key and value
// extremes, every command and every error status. Random commands then fill
// and drain the table over and over. Each command word is run through a shadow
// copy of the table when it is accepted. The result words are compared field
// by field in arrival order. Sender gaps and receiver stalls change from
// phase to phase, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module ordered_key_value_table_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kvt_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int KEY_POOL_N   = 16;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [HIT_W-1:0]       hit;
        logic [KEY_FIELD_W-1:0] key;
        logic [VAL_FIELD_W-1:0] value;
        logic [COUNT_W-1:0]     count;
    } table_reply_t;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [KEY_FIELD_W-1:0] key;
        logic [VAL_FIELD_W-1:0] value;
        logic [POS_W-1:0]       pos;
        logic                   fixed;
        table_reply_t           reply;
    } probe_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    logic [KEY_FIELD_W-1:0] shadow_keys [DEPTH];
    logic [VAL_FIELD_W-1:0] shadow_values [DEPTH];
    int                     shadow_count;

    table_reply_t pending_replies [$];
    probe_row_t   probe_rows [$];
    logic [KEY_FIELD_W-1:0] key_pool [KEY_POOL_N];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int quiet_cycles   = 0;
    bit filling        = 1'b1;

    ordered_key_value_table_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // shadow table: works out the reply and updates the entries
    function automatic table_reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [KEY_FIELD_W-1:0] key,
                                                   input logic [VAL_FIELD_W-1:0] value,
                                                   input logic [POS_W-1:0] pos);
        table_reply_t r;
        bit           found;
        int           at;
        int           i;
        r     = '0;
        found = 1'b0;
        at    = 0;
        for (i = 0; i < shadow_count; i++) begin
            if (!found && shadow_keys[i] == key) begin
                found = 1'b1;
                at    = i;
            end
        end
        case (cmd)
            CMD_LOOKUP: begin
                if (found) r.hit = at[HIT_W-1:0];
                else r.status = ST_ABSENT;
            end
            CMD_INSERT: begin
                if (found) begin
                    r.status = ST_PRESENT;
                    r.hit    = at[HIT_W-1:0];
                end else if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_keys[shadow_count]   = key;
                    shadow_values[shadow_count] = value;
                    r.hit = shadow_count[HIT_W-1:0];
                    shadow_count++;
                end
            end
            CMD_REMOVE: begin
                if (!found) begin
                    r.status = ST_ABSENT;
                end else if (shadow_values[at] != value) begin
                    r.status = ST_MISMATCH;
                    r.hit    = at[HIT_W-1:0];
                end else begin
                    for (i = at; i + 1 < shadow_count; i++) begin
                        shadow_keys[i]   = shadow_keys[i + 1];
                        shadow_values[i] = shadow_values[i + 1];
                    end
                    shadow_count--;
                    r.hit = at[HIT_W-1:0];
                end
            end
            CMD_READ: begin
                r.hit = pos;
                if (pos < shadow_count) begin
                    r.key   = shadow_keys[pos];
                    r.value = shadow_values[pos];
                end else begin
                    r.status = ST_BADPOS;
                end
            end
            CMD_WRITE: begin
                r.hit = pos;
                if (pos < shadow_count) shadow_values[pos] = value;
                else r.status = ST_BADPOS;
            end
            default: ;
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic table_reply_t reply_of(input logic [STATUS_W-1:0] status,
                                              input logic [HIT_W-1:0] hit,
                                              input logic [KEY_FIELD_W-1:0] key,
                                              input logic [VAL_FIELD_W-1:0] value,
                                              input logic [COUNT_W-1:0] count);
        table_reply_t r;
        r.status = status;
        r.hit    = hit;
        r.key    = key;
        r.value  = value;
        r.count  = count;
        return r;
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [31:0] key,
                           input logic [31:0] value, input logic [POS_W-1:0] pos,
                           input logic fixed, input table_reply_t reply);
        probe_row_t row;
        row.cmd   = cmd;
        row.key   = key;
        row.value = value;
        row.pos   = pos;
        row.fixed = fixed;
        row.reply = reply;
        probe_rows = {probe_rows, row};
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [31:0] key,
                                input logic [31:0] value, input logic [POS_W-1:0] pos,
                                input logic fixed, input table_reply_t fixed_reply);
        table_reply_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, pos, value, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_command(cmd, key, value, pos);
        pending_replies = {pending_replies, (fixed ? fixed_reply : predicted)};
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed fill and drain sequences with random content
    task automatic send_random_command();
        logic [CMD_W-1:0] cmd;
        logic [31:0]      key;
        logic [31:0]      value;
        logic [POS_W-1:0] pos;
        int               roll;
        int               slot;
        if (shadow_count == DEPTH) filling = 1'b0;
        if (shadow_count == 0) filling = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 3) cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        else if (roll < 18) cmd = CMD_LOOKUP;
        else if (roll < 33) cmd = CMD_READ;
        else if (roll < 45) cmd = CMD_WRITE;
        else if (roll < 85) cmd = filling ? CMD_INSERT : CMD_REMOVE;
        else cmd = filling ? CMD_REMOVE : CMD_INSERT;

        value = random_value();
        pos   = POS_W'($urandom_range(0, 15));
        slot  = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
        roll  = $urandom_range(0, 99);
        if (shadow_count > 0 && roll < ((cmd == CMD_INSERT) ? 20 : 70))
            key = shadow_keys[slot];
        else if (roll < 85)
            key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        else
            key = $urandom;

        if (cmd == CMD_REMOVE && shadow_count > 0 && key == shadow_keys[slot]
            && $urandom_range(0, 99) < 80)
            value = shadow_values[slot];
        if ((cmd == CMD_READ || cmd == CMD_WRITE) && shadow_count > 0
            && $urandom_range(0, 99) < 75)
            pos = POS_W'($urandom_range(0, shadow_count - 1));

        send_command(cmd, key, value, pos, 1'b0, '0);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        table_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: result word with none expected, tuser %h tdata %h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("hit_position", 32'(want.hit), 32'(m_tdata[3:0]));
                check_field("out_key", want.key, m_tdata[35:4]);
                check_field("out_value", want.value, m_tdata[67:36]);
                check_field("entry_count", 32'(want.count), 32'(m_tdata[72:68]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("[ordered_key_value_table_core] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        int phase;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_LOOKUP;
        aresetn  = 1'b0;
        shadow_count = 0;
        for (i = 0; i < DEPTH; i++) begin
            shadow_keys[i]   = '0;
            shadow_values[i] = '0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < KEY_POOL_N; i++) key_pool[i] = $urandom;

        // empty table, extremes, the absent, bad-position, present and mismatch statuses
        add_row(CMD_LOOKUP, 32'h0, 32'h0, 4'd0, 1'b1,
                reply_of(ST_ABSENT, 4'd0, '0, '0, 5'd0));
        add_row(CMD_READ, 32'h0, 32'h0, 4'd0, 1'b1,
                reply_of(ST_BADPOS, 4'd0, '0, '0, 5'd0));
        add_row(CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1,
                reply_of(ST_BADPOS, 4'd15, '0, '0, 5'd0));
        add_row(CMD_REMOVE, 32'h0, 32'h0, 4'd0, 1'b1,
                reply_of(ST_ABSENT, 4'd0, '0, '0, 5'd0));
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 4'd0, 1'b1,
                reply_of(ST_OK, 4'd0, '0, '0, 5'd1));
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 4'd0, 1'b1,
                reply_of(ST_PRESENT, 4'd0, '0, '0, 5'd1));
        add_row(CMD_READ, 32'h0, 32'h0, 4'd0, 1'b1,
                reply_of(ST_OK, 4'd0, 32'hFFFF_FFFF, 32'h8000_0000, 5'd1));
        add_row(CMD_REMOVE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 4'd0, 1'b1,
                reply_of(ST_MISMATCH, 4'd0, '0, '0, 5'd1));
        add_row(CMD_WRITE, 32'h0, 32'h7FFF_FFFF, 4'd0, 1'b1,
                reply_of(ST_OK, 4'd0, '0, '0, 5'd1));
        add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd15, 1'b1,
                reply_of(ST_OK, 4'd0, '0, '0, 5'd1));
        add_row(CMD_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1,
                reply_of(ST_OK, 4'd0, '0, '0, 5'd1));
        add_row(CMD_INSERT, 32'h0, 32'h0, 4'd15, 1'b1,
                reply_of(ST_OK, 4'd1, '0, '0, 5'd2));
        // fill up to the last entry
        for (i = 0; i < DEPTH - 2; i++)
            add_row(CMD_INSERT, 32'h0000_0100 + i, $urandom,
                    POS_W'($urandom_range(0, 15)), 1'b0, '0);
        // presence is checked before fullness
        add_row(CMD_INSERT, 32'h0, 32'h1234_5678, 4'd0, 1'b1,
                reply_of(ST_PRESENT, 4'd1, '0, '0, 5'd16));
        add_row(CMD_INSERT, 32'h5555_AAAA, 32'h1, 4'd0, 1'b1,
                reply_of(ST_FULL, 4'd0, '0, '0, 5'd16));
        add_row(CMD_READ, 32'h0, 32'h0, 4'd15, 1'b0, '0);
        // removing the first entry shifts the whole row down
        add_row(CMD_REMOVE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 4'd0, 1'b1,
                reply_of(ST_OK, 4'd0, '0, '0, 5'd15));
        add_row(CMD_READ, 32'h0, 32'h0, 4'd15, 1'b1,
                reply_of(ST_BADPOS, 4'd15, '0, '0, 5'd15));
        add_row(CMD_READ, 32'h0, 32'h0, 4'd14, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < probe_rows.size(); i++)
            send_command(probe_rows[i].cmd, probe_rows[i].key, probe_rows[i].value,
                         probe_rows[i].pos, probe_rows[i].fixed, probe_rows[i].reply);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_off_left  = HOLD_CYCLES;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            repeat (130) send_random_command();
        end

        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ordered_key_value_table_core] OK");
        else
            $display("[ordered_key_value_table_core] ERROR");
        $finish;
    end

endmodule
